// ----- rtl/core/assert_macros.svh -----
// Assertion helpers, included by flvp_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- rtl/core/flvp_pkg.sv -----
package flvp_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [2:0] REG_AAC_FORMAT = 3'd0;
	localparam logic [2:0] REG_AVC_CODEC  = 3'd1;
	localparam logic [2:0] REG_HEVC_CODEC = 3'd2;
	localparam logic [2:0] REG_AV1_CODEC  = 3'd3;
	localparam logic [2:0] REG_VVC_CODEC  = 3'd4;

	localparam logic [3:0] AAC_FORMAT_RST = 4'd10;
	localparam logic [3:0] AVC_CODEC_RST  = 4'd7;
	localparam logic [3:0] HEVC_CODEC_RST = 4'd12;
	localparam logic [3:0] AV1_CODEC_RST  = 4'd13;
	localparam logic [3:0] VVC_CODEC_RST  = 4'd14;

	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_TAG      = 2'd1;
	localparam logic [1:0] KIND_SIG_ERR  = 2'd2;
	localparam logic [1:0] KIND_SIZE_ERR = 2'd3;

	localparam logic [7:0] TAG_AUDIO = 8'd8;
	localparam logic [7:0] TAG_VIDEO = 8'd9;

	typedef struct packed {
		logic [3:0] aac_format_id;
		logic [3:0] avc_codec_id;
		logic [3:0] hevc_codec_id;
		logic [3:0] av1_codec_id;
		logic [3:0] vvc_codec_id;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         tag_code;
		logic [23:0]        data_size;
		logic [31:0]        timestamp;
		logic [23:0]        stream_id;
		logic [3:0]         upper_nibble;
		logic [3:0]         lower_nibble;
		logic [7:0]         packet_code;
		logic signed [23:0] composition_time;
		logic [31:0]        prev_tag_size;
		logic [7:0]         version;
		logic [39:0]        header_info;
	} res_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] val;
		unique case (idx)
			2'd0: val = 8'h46;
			2'd1: val = 8'h4C;
			2'd2: val = 8'h56;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

// ----- rtl/core/flvp_if.sv -----
interface flvp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       restart;

	modport source (output valid, output stream_byte, output restart, input ready);
	modport sink (input valid, input stream_byte, input restart, output ready);
endinterface

interface flvp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         tag_code;
	logic [23:0]        data_size;
	logic [31:0]        timestamp;
	logic [23:0]        stream_id;
	logic [3:0]         upper_nibble;
	logic [3:0]         lower_nibble;
	logic [7:0]         packet_code;
	logic signed [23:0] composition_time;
	logic [31:0]        prev_tag_size;
	logic [7:0]         version;
	logic [39:0]        header_info;

	modport source (
		output valid, output kind, output tag_code, output data_size, output timestamp,
		output stream_id, output upper_nibble, output lower_nibble, output packet_code,
		output composition_time, output prev_tag_size, output version, output header_info,
		input ready
	);
	modport sink (
		input valid, input kind, input tag_code, input data_size, input timestamp,
		input stream_id, input upper_nibble, input lower_nibble, input packet_code,
		input composition_time, input prev_tag_size, input version, input header_info,
		output ready
	);
endinterface

// ----- rtl/core/flv_tag_header_parser_unit.sv -----
// Throughput: one stream byte per cycle while the result side keeps ready high.
// The parser state updates in one pass as a beat leaves the input register.
// Reset is asynchronous, active low: the parser expects a file header,
// all of the parser's held fields clear and the codec registers return to their defaults.
module flv_tag_header_parser_unit
	import flvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	flvp_in_if.sink           stream,
	flvp_out_if.source        result
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       advance;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1    <= stream.stream_byte;
			restart_s1 <= stream.restart;
		end
	end

	flvp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	flvp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (advance),
		.byte_in    (byte_s1),
		.restart    (restart_s1),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.kind             = out_q.kind;
	assign result.tag_code         = out_q.tag_code;
	assign result.data_size        = out_q.data_size;
	assign result.timestamp        = out_q.timestamp;
	assign result.stream_id        = out_q.stream_id;
	assign result.upper_nibble     = out_q.upper_nibble;
	assign result.lower_nibble     = out_q.lower_nibble;
	assign result.packet_code      = out_q.packet_code;
	assign result.composition_time = out_q.composition_time;
	assign result.prev_tag_size    = out_q.prev_tag_size;
	assign result.version          = out_q.version;
	assign result.header_info      = out_q.header_info;

endmodule

// ----- rtl/core/flvp_cfg_regs.sv -----
module flvp_cfg_regs
	import flvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aac_format_id <= AAC_FORMAT_RST;
			cfg_q.avc_codec_id  <= AVC_CODEC_RST;
			cfg_q.hevc_codec_id <= HEVC_CODEC_RST;
			cfg_q.av1_codec_id  <= AV1_CODEC_RST;
			cfg_q.vvc_codec_id  <= VVC_CODEC_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_AAC_FORMAT: cfg_q.aac_format_id <= pwdata[3:0];
				REG_AVC_CODEC:  cfg_q.avc_codec_id  <= pwdata[3:0];
				REG_HEVC_CODEC: cfg_q.hevc_codec_id <= pwdata[3:0];
				REG_AV1_CODEC:  cfg_q.av1_codec_id  <= pwdata[3:0];
				REG_VVC_CODEC:  cfg_q.vvc_codec_id  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_AAC_FORMAT: prdata = {{(APB_DW-4){1'b0}}, cfg_q.aac_format_id};
			REG_AVC_CODEC:  prdata = {{(APB_DW-4){1'b0}}, cfg_q.avc_codec_id};
			REG_HEVC_CODEC: prdata = {{(APB_DW-4){1'b0}}, cfg_q.hevc_codec_id};
			REG_AV1_CODEC:  prdata = {{(APB_DW-4){1'b0}}, cfg_q.av1_codec_id};
			REG_VVC_CODEC:  prdata = {{(APB_DW-4){1'b0}}, cfg_q.vvc_codec_id};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/flvp_parser.sv -----
`include "assert_macros.svh"

module flvp_parser
	import flvp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat_valid,
	input  logic [7:0] byte_in,
	input  logic       restart,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	localparam logic [3:0] PH_HDR     = 4'd0;
	localparam logic [3:0] PH_HDR_BAD = 4'd1;
	localparam logic [3:0] PH_TAG     = 4'd2;
	localparam logic [3:0] PH_MEDIA   = 4'd3;
	localparam logic [3:0] PH_DETAIL  = 4'd4;
	localparam logic [3:0] PH_CTS     = 4'd5;
	localparam logic [3:0] PH_SKIP    = 4'd6;
	localparam logic [3:0] PH_PREV    = 4'd7;
	localparam logic [3:0] PH_HALT    = 4'd8;

	logic [3:0]  phase_q, phase_n;
	logic [23:0] count_q, count_n;
	logic [7:0]  tag_code_q, tag_code_n;
	logic [23:0] size_q, size_n;
	logic [31:0] ts_q, ts_n;
	logic [23:0] sid_q, sid_n;
	logic [7:0]  media_q, media_n;
	logic [7:0]  detail_q, detail_n;
	logic [23:0] cts_q, cts_n;
	logic [31:0] prev_q, prev_n;
	logic [7:0]  ver_q, ver_n;
	logic [39:0] hinfo_q, hinfo_n;

	logic        do_skip;
	logic [23:0] skip_left;
	logic        tag_f;
	logic        hdr_f;
	logic [1:0]  kind;
	logic        extra;
	logic [23:0] need;
	logic        in_halt;
	logic        in_hdr;
	logic        err_res;

	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		tag_code_n = tag_code_q;
		size_n     = size_q;
		ts_n       = ts_q;
		sid_n      = sid_q;
		media_n    = media_q;
		detail_n   = detail_q;
		cts_n      = cts_q;
		prev_n     = prev_q;
		ver_n      = ver_q;
		hinfo_n    = hinfo_q;
		do_skip    = 1'b0;
		skip_left  = '0;
		res_valid  = 1'b0;
		kind       = KIND_HEADER;
		tag_f      = 1'b0;
		hdr_f      = 1'b0;
		extra      = 1'b0;
		need       = '0;
		if (beat_valid && restart) begin
			phase_n    = PH_HDR;
			count_n    = '0;
			tag_code_n = '0;
			size_n     = '0;
			ts_n       = '0;
			sid_n      = '0;
			media_n    = '0;
			detail_n   = '0;
			cts_n      = '0;
			prev_n     = '0;
			ver_n      = '0;
			hinfo_n    = '0;
		end else if (beat_valid) begin
			unique case (phase_q)
				PH_HDR, PH_HDR_BAD: begin
					if (count_q < 24'd3) begin
						if (byte_in != sig_byte(count_q[1:0])) begin
							phase_n = PH_HDR_BAD;
						end
					end else if (count_q == 24'd3) begin
						ver_n = byte_in;
					end else if (count_q <= 24'd8) begin
						hinfo_n = {hinfo_q[31:0], byte_in};
					end else begin
						prev_n = {prev_q[23:0], byte_in};
					end
					if (count_q >= 24'd12) begin
						res_valid = 1'b1;
						if (phase_q == PH_HDR_BAD) begin
							phase_n = PH_HALT;
							kind    = KIND_SIG_ERR;
						end else begin
							phase_n = PH_TAG;
							count_n = '0;
							kind    = KIND_HEADER;
							hdr_f   = 1'b1;
						end
					end else begin
						count_n = count_q + 24'd1;
					end
				end
				PH_TAG: begin
					if (count_q == 24'd0) begin
						tag_code_n = byte_in;
						size_n     = '0;
						ts_n       = '0;
						sid_n      = '0;
						media_n    = '0;
						detail_n   = '0;
						cts_n      = '0;
						prev_n     = '0;
						ver_n      = '0;
						hinfo_n    = '0;
					end else if (count_q <= 24'd3) begin
						size_n = {size_q[15:0], byte_in};
					end else if (count_q <= 24'd6) begin
						ts_n = {8'h00, ts_q[15:0], byte_in};
					end else if (count_q == 24'd7) begin
						ts_n = {byte_in, ts_q[23:0]};
					end else begin
						sid_n = {sid_q[15:0], byte_in};
					end
					if (count_q < 24'd10) begin
						count_n = count_q + 24'd1;
					end else begin
						count_n = '0;
						if (tag_code_q == TAG_AUDIO || tag_code_q == TAG_VIDEO) begin
							if (size_q == 24'd0) begin
								phase_n   = PH_HALT;
								res_valid = 1'b1;
								kind      = KIND_SIZE_ERR;
								tag_f     = 1'b1;
							end else begin
								phase_n = PH_MEDIA;
							end
						end else begin
							do_skip   = 1'b1;
							skip_left = size_q;
						end
					end
				end
				PH_MEDIA: begin
					media_n = byte_in;
					if (tag_code_q == TAG_AUDIO) begin
						extra = byte_in[7:4] == cfg.aac_format_id;
						need  = 24'd2;
					end else begin
						extra = byte_in[3:0] == cfg.avc_codec_id
							|| byte_in[3:0] == cfg.hevc_codec_id
							|| byte_in[3:0] == cfg.av1_codec_id
							|| byte_in[3:0] == cfg.vvc_codec_id;
						need  = 24'd5;
					end
					if (!extra) begin
						do_skip   = 1'b1;
						skip_left = size_q - 24'd1;
					end else if (size_q < need) begin
						phase_n   = PH_HALT;
						res_valid = 1'b1;
						kind      = KIND_SIZE_ERR;
						tag_f     = 1'b1;
					end else begin
						phase_n = PH_DETAIL;
					end
				end
				PH_DETAIL: begin
					detail_n = byte_in;
					if (tag_code_q == TAG_AUDIO) begin
						do_skip   = 1'b1;
						skip_left = size_q - 24'd2;
					end else begin
						phase_n = PH_CTS;
						count_n = '0;
					end
				end
				PH_CTS: begin
					cts_n = {cts_q[15:0], byte_in};
					if (count_q < 24'd2) begin
						count_n = count_q + 24'd1;
					end else begin
						do_skip   = 1'b1;
						skip_left = size_q - 24'd5;
					end
				end
				PH_SKIP: begin
					count_n = count_q - 24'd1;
					if (count_n == 24'd0) begin
						phase_n = PH_PREV;
					end
				end
				PH_PREV: begin
					prev_n = {prev_q[23:0], byte_in};
					if (count_q < 24'd3) begin
						count_n = count_q + 24'd1;
					end else begin
						phase_n   = PH_TAG;
						count_n   = '0;
						res_valid = 1'b1;
						kind      = KIND_TAG;
						tag_f     = 1'b1;
					end
				end
				default: ;
			endcase
			if (do_skip) begin
				count_n = skip_left;
				phase_n = (skip_left == 24'd0) ? PH_PREV : PH_SKIP;
			end
		end
	end

	always_comb begin
		res                  = '0;
		res.kind             = kind;
		if (tag_f) begin
			res.tag_code         = tag_code_n;
			res.data_size        = size_n;
			res.timestamp        = ts_n;
			res.stream_id        = sid_n;
			res.upper_nibble     = media_n[7:4];
			res.lower_nibble     = media_n[3:0];
			res.packet_code      = detail_n;
			res.composition_time = cts_n;
			res.prev_tag_size    = prev_n;
		end
		if (hdr_f) begin
			res.prev_tag_size = prev_n;
			res.version       = ver_n;
			res.header_info   = hinfo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			count_q    <= '0;
			tag_code_q <= '0;
			size_q     <= '0;
			ts_q       <= '0;
			sid_q      <= '0;
			media_q    <= '0;
			detail_q   <= '0;
			cts_q      <= '0;
			prev_q     <= '0;
			ver_q      <= '0;
			hinfo_q    <= '0;
		end else begin
			phase_q    <= phase_n;
			count_q    <= count_n;
			tag_code_q <= tag_code_n;
			size_q     <= size_n;
			ts_q       <= ts_n;
			sid_q      <= sid_n;
			media_q    <= media_n;
			detail_q   <= detail_n;
			cts_q      <= cts_n;
			prev_q     <= prev_n;
			ver_q      <= ver_n;
			hinfo_q    <= hinfo_n;
		end
	end

	assign in_halt = phase_q == PH_HALT;
	assign in_hdr  = phase_q == PH_HDR || phase_q == PH_HDR_BAD;
	assign err_res = res_valid && (res.kind == KIND_SIG_ERR || res.kind == KIND_SIZE_ERR);

	`ASSERT_NEXT(halt_is_sticky, clk, arst_n, beat_valid && !restart && in_halt, in_halt)
	`ASSERT_IMPLIES(result_needs_beat, clk, arst_n, res_valid, beat_valid && !restart)
	`ASSERT_NEXT(error_halts, clk, arst_n, err_res, in_halt)
	`ASSERT_IMPLIES(header_count_bound, clk, arst_n, in_hdr, count_q <= 24'd12)

endmodule
